// ===== hdl/gse_pkg.sv =====
`default_nettype none

package gse_pkg;

   localparam logic [7:0] MARK_D5 = 8'hD5;
   localparam logic [7:0] MARK_AA = 8'hAA;
   localparam logic [7:0] MARK_96 = 8'h96;
   localparam logic [7:0] MARK_AD = 8'hAD;
   localparam logic [7:0] MARK_DE = 8'hDE;
   localparam logic [7:0] GAP_FF  = 8'hFF;
   localparam logic [5:0] FORMAT_22 = 6'h22;
   localparam logic [5:0] SIDE_BIT  = 6'h20;

   localparam int unsigned SECTOR_BYTES = 512;
   localparam logic [9:0] SECTOR_LAST_BYTE = 10'(SECTOR_BYTES - 1);

   localparam logic [5:0] HEADER_LAST_POS = 6'd35;
   localparam logic [5:0] GROUP_LAST_POS  = 6'd3;
   localparam logic [5:0] CLOSE_LAST_POS  = 6'd9;

   localparam logic [7:0] GCR_MAP [64] = '{
      8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
      8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
      8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
      8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
      8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
      8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
      8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
      8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
   };

   typedef enum logic [1:0] {
      JOB_HEADER,
      JOB_GROUP,
      JOB_CLOSE
   } job_kind_type;

   // header: b0 track, b1 sector, b2 side, b3 check
   // group:  b0..b2 whitened bytes
   // close:  b0, b1 whitened bytes, b2 sum_a, b3 sum_b, b4 sum_c
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   b0;
      logic [7:0]   b1;
      logic [7:0]   b2;
      logic [7:0]   b3;
      logic [7:0]   b4;
   } job_type;

   function automatic logic [5:0] pack_top(input logic [7:0] x, input logic [7:0] y,
                                           input logic [7:0] z);
      return {x[7:6], y[7:6], z[7:6]};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/gcr_sector_encoder.sv =====
// a request is held in an input register, then loaded as a job into job_ff; each disk byte is registered at the output
// throughput: one result per cycle while rsp_ready holds; a start request gives 36 disk bytes, a data
//    request closing a group 4, the closing byte 10, other data none
// the result emitter (one disk byte per cycle while rsp_ready holds) sets the rate
// reset: synchronous, active high; clears checksums and byte count, sets double_sided
`default_nettype none

module gcr_sector_encoder
   import gse_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_op,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [6:0] req_track_number,
   input  wire logic [3:0] req_sector_number,
   input  wire logic       req_head_select,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_gcr_byte,
   output logic            rsp_last
);

   logic       double_sided_ff;
   logic       in_valid_ff, in_valid_in;
   logic       op_ff;
   logic [7:0] data_byte_ff;
   logic [6:0] track_number_ff;
   logic [3:0] sector_number_ff;
   logic       head_select_ff;
   logic       in_take;
   logic       job_valid;
   logic       job_ready;
   job_type    job;

   assign in_take = in_valid_ff && (job_ready || !job_valid);
   assign req_ready = !in_valid_ff || in_take;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         double_sided_ff <= 1'b1;
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            double_sided_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff <= req_op;
         data_byte_ff <= req_data_byte;
         track_number_ff <= req_track_number;
         sector_number_ff <= req_sector_number;
         head_select_ff <= req_head_select;
      end
   end

   gse_csum u_csum (
      .clock         (clock),
      .reset         (reset),
      .fire          (in_take),
      .op            (op_ff),
      .data_byte     (data_byte_ff),
      .track_number  (track_number_ff),
      .sector_number (sector_number_ff),
      .head_select   (head_select_ff),
      .double_sided  (double_sided_ff),
      .job_valid     (job_valid),
      .job           (job)
   );

   gse_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .job_load     (in_take && job_valid),
      .job          (job),
      .job_ready    (job_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_gcr_byte (rsp_gcr_byte),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

// ===== hdl/gse_csum.sv =====
`default_nettype none

module gse_csum
   import gse_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire logic       op,
   input  wire logic [7:0] data_byte,
   input  wire logic [6:0] track_number,
   input  wire logic [3:0] sector_number,
   input  wire logic       head_select,
   input  wire logic       double_sided,
   output logic            job_valid,
   output job_type         job
);

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   logic [8:0] sum_a_ff, sum_b_ff, sum_c_ff;
   logic [8:0] sum_a_in, sum_b_in, sum_c_in;
   logic [9:0] byte_index_ff, byte_index_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_first_ff, held_first_in;
   logic [7:0] held_second_ff, held_second_in;
   logic [7:0] third;
   logic [5:0] side;
   logic [5:0] check;
   logic       in_sector;

   assign in_sector = !byte_index_ff[9];

   always_comb begin
      side = ((double_sided && head_select) ? SIDE_BIT : 6'h00) | {5'b0, track_number[6]};
      check = track_number[5:0] ^ {2'b00, sector_number} ^ side ^ FORMAT_22;

      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      sum_c_in = sum_c_ff;
      byte_index_in = byte_index_ff;
      phase_in = phase_ff;
      held_first_in = held_first_ff;
      held_second_in = held_second_ff;
      third = 8'h00;
      job_valid = 1'b0;
      job = '{kind: JOB_HEADER, b0: {2'b00, track_number[5:0]}, b1: {4'h0, sector_number},
              b2: {2'b00, side}, b3: {2'b00, check}, b4: 8'h00};

      if (!op) begin
         sum_a_in = '0;
         sum_b_in = '0;
         sum_c_in = '0;
         byte_index_in = '0;
         phase_in = PHASE_FIRST;
         job_valid = 1'b1;
      end else if (in_sector) begin
         byte_index_in = byte_index_ff + 10'd1;
         case (phase_ff)
            PHASE_FIRST: begin
               sum_a_in = {1'b0, sum_a_ff[6:0], sum_a_ff[7]};
               sum_c_in = sum_c_ff + {1'b0, data_byte} + {8'h00, sum_a_ff[7]};
               held_first_in = data_byte ^ sum_a_in[7:0];
               phase_in = PHASE_SECOND;
            end
            PHASE_SECOND: begin
               sum_b_in = sum_b_ff + {1'b0, data_byte} + {8'h00, sum_c_ff[8]};
               sum_c_in = {1'b0, sum_c_ff[7:0]};
               held_second_in = data_byte ^ sum_c_ff[7:0];
               phase_in = PHASE_THIRD;
               if (byte_index_ff == SECTOR_LAST_BYTE) begin
                  job_valid = 1'b1;
                  job = '{kind: JOB_CLOSE, b0: held_first_ff, b1: held_second_in,
                          b2: sum_a_ff[7:0], b3: sum_b_in[7:0], b4: sum_c_in[7:0]};
               end
            end
            default: begin
               sum_a_in = sum_a_ff + {1'b0, data_byte} + {8'h00, sum_b_ff[8]};
               sum_b_in = {1'b0, sum_b_ff[7:0]};
               third = data_byte ^ sum_b_ff[7:0];
               phase_in = PHASE_FIRST;
               job_valid = 1'b1;
               job = '{kind: JOB_GROUP, b0: held_first_ff, b1: held_second_ff,
                       b2: third, b3: 8'h00, b4: 8'h00};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         sum_c_ff <= '0;
         byte_index_ff <= '0;
         phase_ff <= PHASE_FIRST;
      end else if (fire) begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         sum_c_ff <= sum_c_in;
         byte_index_ff <= byte_index_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         held_first_ff <= held_first_in;
         held_second_ff <= held_second_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      byte_index_ff <= 10'(SECTOR_BYTES))
      else $error("byte index past end of sector");

   assert property (@(posedge clock) disable iff (reset)
      byte_index_ff == 10'd0 |-> phase_ff == PHASE_FIRST)
      else $error("group phase out of step with byte index");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_FIRST || phase_ff == PHASE_SECOND || phase_ff == PHASE_THIRD)
      else $error("illegal group phase");

endmodule

`default_nettype wire

// ===== hdl/gse_emit.sv =====
`default_nettype none

module gse_emit
   import gse_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       job_load,
   input  wire job_type    job,
   output logic            job_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_gcr_byte,
   output logic            rsp_last
);

   logic       busy_ff, busy_in;
   job_type    job_ff;
   logic [5:0] pos_ff, pos_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;
   logic       advance;
   logic       final_byte;
   logic [5:0] last_pos;
   logic       use_map;
   logic [5:0] six;
   logic [7:0] raw;
   logic [7:0] out_byte;

   always_comb begin
      case (job_ff.kind)
         JOB_HEADER: last_pos = HEADER_LAST_POS;
         JOB_GROUP:  last_pos = GROUP_LAST_POS;
         default:    last_pos = CLOSE_LAST_POS;
      endcase
   end

   assign advance = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign final_byte = (pos_ff == last_pos);
   assign job_ready = !busy_ff || (advance && final_byte);

   always_comb begin
      use_map = 1'b1;
      six = 6'h00;
      raw = 8'h00;
      case (job_ff.kind)
         JOB_HEADER: begin
            case (pos_ff)
               6'd0:  begin use_map = 1'b0; raw = MARK_D5; end
               6'd1:  begin use_map = 1'b0; raw = MARK_AA; end
               6'd2:  begin use_map = 1'b0; raw = MARK_96; end
               6'd3:  six = job_ff.b0[5:0];
               6'd4:  six = job_ff.b1[5:0];
               6'd5:  six = job_ff.b2[5:0];
               6'd6:  six = FORMAT_22;
               6'd7:  six = job_ff.b3[5:0];
               6'd8:  begin use_map = 1'b0; raw = MARK_DE; end
               6'd9:  begin use_map = 1'b0; raw = MARK_AA; end
               6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15: begin
                  use_map = 1'b0;
                  raw = GAP_FF;
               end
               6'd16: begin use_map = 1'b0; raw = MARK_D5; end
               6'd17: begin use_map = 1'b0; raw = MARK_AA; end
               6'd18: begin use_map = 1'b0; raw = MARK_AD; end
               6'd19: six = job_ff.b1[5:0];
               default: six = 6'h00;
            endcase
         end
         JOB_GROUP: begin
            case (pos_ff)
               6'd0:    six = pack_top(job_ff.b0, job_ff.b1, job_ff.b2);
               6'd1:    six = job_ff.b0[5:0];
               6'd2:    six = job_ff.b1[5:0];
               default: six = job_ff.b2[5:0];
            endcase
         end
         default: begin
            case (pos_ff)
               6'd0:    six = pack_top(job_ff.b0, job_ff.b1, 8'h00);
               6'd1:    six = job_ff.b0[5:0];
               6'd2:    six = job_ff.b1[5:0];
               6'd3:    six = pack_top(job_ff.b4, job_ff.b3, job_ff.b2);
               6'd4:    six = job_ff.b4[5:0];
               6'd5:    six = job_ff.b3[5:0];
               6'd6:    six = job_ff.b2[5:0];
               6'd7:    begin use_map = 1'b0; raw = MARK_DE; end
               6'd8:    begin use_map = 1'b0; raw = MARK_AA; end
               default: begin use_map = 1'b0; raw = GAP_FF; end
            endcase
         end
      endcase
      out_byte = use_map ? GCR_MAP[six] : raw;
   end

   always_comb begin
      busy_in = busy_ff;
      pos_in = pos_ff;
      if (job_load) begin
         busy_in = 1'b1;
         pos_in = 6'd0;
      end else if (advance) begin
         if (final_byte) begin
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff + 6'd1;
         end
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pos_ff <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_load) begin
         job_ff <= job;
      end
      if (advance) begin
         rsp_byte_ff <= out_byte;
         rsp_last_ff <= final_byte;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_gcr_byte = rsp_byte_ff;
   assign rsp_last = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pos_ff <= last_pos)
      else $error("emit position past end of job");

   assert property (@(posedge clock) disable iff (reset)
      job_load |-> !busy_ff || (advance && final_byte))
      else $error("job loaded over one still in progress");

   assert property (@(posedge clock) disable iff (reset)
      advance && final_byte && !job_load |=> !busy_ff && rsp_valid_ff && rsp_last_ff)
      else $error("job end not marked on output");

endmodule

`default_nettype wire

// ===== tb/gcr_sector_encoder_tb.sv =====
`timescale 1ns / 100ps

module gcr_sector_encoder_tb;

   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   localparam int SECTOR_SIZE    = 512;
   localparam int RANDOM_ITEMS   = 330;
   localparam int SECTOR_LEAD    = 24;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 8;
   localparam int REPORT_LIMIT   = 30;

   typedef enum int {
      FILL_RANDOM,
      FILL_ONES,
      FILL_EDGES
   } fill_kind_type;

   // expected disk bytes of the encoder, kept in track order
   class gcr_scoreboard;
      bit         double_sided;
      logic [8:0] sum_a, sum_b, sum_c;
      logic [9:0] byte_index;
      logic [7:0] held_first, held_second;
      logic [7:0] gcr_table [64];
      logic [7:0] expected_bytes [$];
      bit         expected_last [$];
      int         errors, results_seen, headers_sent, sectors_closed;

      function new();
         gcr_table = '{
            8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
            8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
            8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
            8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
            8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
            8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
            8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
            8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
         };
         double_sided = 1'b1;
         sum_a = '0;
         sum_b = '0;
         sum_c = '0;
         byte_index = '0;
         held_first = '0;
         held_second = '0;
         errors = 0;
         results_seen = 0;
         headers_sent = 0;
         sectors_closed = 0;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function void add_byte(logic [7:0] value);
         expected_bytes.push_back(value);
         expected_last.push_back(1'b0);
      endfunction

      function void add_coded(logic [7:0] value);
         add_byte(gcr_table[value[5:0]]);
      endfunction

      // returns 0 when the request is ignored
      function bit note_request(logic op, logic [7:0] data, logic [6:0] track,
                                logic [3:0] sector, logic head);
         logic [5:0] side;
         logic [5:0] check;
         logic [7:0] third;
         int         start_size;
         start_size = expected_bytes.size();
         if (op == OP_START) begin
            side = (double_sided && head) ? 6'h20 : 6'h00;
            side[0] = track[6];
            check = track[5:0] ^ {2'b00, sector} ^ side ^ 6'h22;
            sum_a = '0;
            sum_b = '0;
            sum_c = '0;
            byte_index = '0;
            add_byte(8'hD5);
            add_byte(8'hAA);
            add_byte(8'h96);
            add_coded({2'b00, track[5:0]});
            add_coded({4'h0, sector});
            add_coded({2'b00, side});
            add_coded(8'h22);
            add_coded({2'b00, check});
            add_byte(8'hDE);
            add_byte(8'hAA);
            repeat (6) add_byte(8'hFF);
            add_byte(8'hD5);
            add_byte(8'hAA);
            add_byte(8'hAD);
            add_coded({4'h0, sector});
            repeat (16) add_coded(8'h00);
            headers_sent++;
         end else if (byte_index < SECTOR_SIZE) begin
            case (byte_index % 3)
               0: begin
                  sum_a = {sum_a[7:0], 1'b0};
                  if (sum_a[8]) sum_a = sum_a + 9'd1;
                  sum_c = sum_c + data;
                  if (sum_a[8]) begin
                     sum_c = sum_c + 9'd1;
                     sum_a[8] = 1'b0;
                  end
                  held_first = data ^ sum_a[7:0];
               end
               1: begin
                  sum_b = sum_b + data;
                  if (sum_c > 9'h0FF) begin
                     sum_b = sum_b + 9'd1;
                     sum_c[8] = 1'b0;
                  end
                  held_second = data ^ sum_c[7:0];
                  if (byte_index == SECTOR_SIZE - 1) begin
                     add_coded({2'b00, held_first[7:6], held_second[7:6], 2'b00});
                     add_coded(held_first);
                     add_coded(held_second);
                     add_coded({2'b00, sum_c[7:6], sum_b[7:6], sum_a[7:6]});
                     add_coded(sum_c[7:0]);
                     add_coded(sum_b[7:0]);
                     add_coded(sum_a[7:0]);
                     add_byte(8'hDE);
                     add_byte(8'hAA);
                     add_byte(8'hFF);
                     sectors_closed++;
                  end
               end
               default: begin
                  sum_a = sum_a + data;
                  if (sum_b > 9'h0FF) begin
                     sum_a = sum_a + 9'd1;
                     sum_b[8] = 1'b0;
                  end
                  third = data ^ sum_b[7:0];
                  add_coded({2'b00, held_first[7:6], held_second[7:6], third[7:6]});
                  add_coded(held_first);
                  add_coded(held_second);
                  add_coded(third);
               end
            endcase
            byte_index = byte_index + 10'd1;
         end else begin
            return 1'b0;
         end
         if (expected_bytes.size() > start_size)
            expected_last[expected_last.size() - 1] = 1'b1;
         return 1'b1;
      endfunction

      function void check_result(logic [7:0] got_byte, logic got_last);
         logic [7:0] want_byte;
         bit         want_last;
         results_seen++;
         if (expected_bytes.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: disk byte with none expected, expected none actual %h last %b",
                        $time, got_byte, got_last);
            return;
         end
         want_byte = expected_bytes.pop_front();
         want_last = expected_last.pop_front();
         if (got_byte !== want_byte) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: gcr_byte expected %h actual %h", $time, want_byte, got_byte);
         end
         if (got_last !== want_last) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: last expected %b actual %b", $time, want_last, got_last);
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic       csr_wr_data;
   logic       req_valid;
   logic       req_ready;
   logic       req_op;
   logic [7:0] req_data_byte;
   logic [6:0] req_track_number;
   logic [3:0] req_sector_number;
   logic       req_head_select;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_gcr_byte;
   logic       rsp_last;

   gcr_scoreboard sb = new();

   int burst_left = 0;
   int counted_items = 0;
   int total_requests = 0;
   int hold_after_results = 0;
   int quiet_cycles = 0;

   gcr_sector_encoder u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_data_byte     (req_data_byte),
      .req_track_number  (req_track_number),
      .req_sector_number (req_sector_number),
      .req_head_select   (req_head_select),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_gcr_byte      (rsp_gcr_byte),
      .rsp_last          (rsp_last)
   );

   always #1 clock = ~clock;

   // called at a falling edge, returns at a falling edge
   task automatic send_request(input logic op, input logic [7:0] data,
                               input logic [6:0] track, input logic [3:0] sector,
                               input logic head);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_data_byte     <= data;
      req_track_number  <= track;
      req_sector_number <= sector;
      req_head_select   <= head;
      do @(posedge clock); while (!req_ready);
      counted_items += sb.note_request(op, data, track, sector, head);
      total_requests++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_start(input logic [6:0] track, input logic [3:0] sector,
                             input logic head);
      send_request(OP_START, 8'($urandom), track, sector, head);
   endtask

   task automatic send_data(input logic [7:0] data);
      send_request(OP_DATA, data, 7'($urandom_range(0, 79)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_double_sided(input logic value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.double_sided = value;
   endtask

   function automatic logic [7:0] fill_byte(fill_kind_type kind);
      logic [7:0] edges [4];
      edges = '{8'h00, 8'hFF, 8'h80, 8'h7F};
      case (kind)
         FILL_ONES:  return 8'hFF;
         FILL_EDGES: return edges[$urandom_range(0, 3)];
         default:    return 8'($urandom);
      endcase
   endfunction

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_gcr_byte, rsp_last);
   end

   // watchdog on lack of progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result receiver: changing stall pattern plus one long hold
   initial begin
      int          mode_left;
      int          mode;
      logic [31:0] pattern;
      mode_left = 0;
      mode = 0;
      pattern = '0;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_after_results > 0 && sb.results_seen >= hold_after_results) begin
            hold_after_results = 0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            pattern = $urandom;
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         case (mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= pattern[mode_left % 32];
         endcase
         @(negedge clock);
      end
   end

   initial begin
      int            full_sectors;
      int            seq_kind;
      int            count;
      bit            first_seq;
      fill_kind_type fill;
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_valid = 1'b0;
      req_op = OP_START;
      req_data_byte = '0;
      req_track_number = '0;
      req_sector_number = '0;
      req_head_select = 1'b0;
      full_sectors = 0;
      first_seq = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // data straight after reset, no start
      send_data(8'hFF);
      send_data(8'h00);
      send_data(8'hC3);
      send_data(8'h3C);
      send_data(8'h80);
      // start in the middle of a group, header extremes
      send_start(7'd0, 4'd0, 1'b0);
      send_start(7'd79, 4'd15, 1'b1);
      send_start(7'd64, 4'd12, 1'b0);
      send_data(8'hAA);
      send_data(8'h55);
      send_data(8'h01);
      wait_idle();
      write_double_sided(1'b0);
      send_start(7'd79, 4'd11, 1'b1);
      send_start(7'd1, 4'd5, 1'b1);
      send_data(8'h7F);
      send_data(8'hFE);
      send_data(8'h80);
      wait_idle();
      write_double_sided(1'b1);
      send_start(7'd42, 4'd3, 1'b1);

      counted_items = 0;
      hold_after_results = sb.results_seen + 100;
      while (counted_items < RANDOM_ITEMS || full_sectors < 1) begin
         if (!first_seq && $urandom_range(0, 2) == 0) begin
            wait_idle();
            write_double_sided(1'($urandom_range(0, 1)));
         end
         seq_kind = (full_sectors == 0 && counted_items >= SECTOR_LEAD) ? 0
                    : $urandom_range(5, 9);
         first_seq = 1'b0;
         if (seq_kind <= 4) begin
            // whole sector, then a few bytes past its end
            fill = fill_kind_type'($urandom_range(0, 5) < 4 ? FILL_RANDOM
                                   : $urandom_range(FILL_ONES, FILL_EDGES));
            send_start(7'($urandom_range(0, 79)), 4'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)));
            repeat (SECTOR_SIZE) send_data(fill_byte(fill));
            repeat ($urandom_range(1, 3)) send_data(8'($urandom));
            full_sectors++;
         end else if (seq_kind <= 7) begin
            // sector cut short by the next start
            count = $urandom_range(0, 40);
            send_start(7'($urandom_range(0, 79)), 4'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)));
            repeat (count) send_data(8'($urandom));
         end else begin
            count = $urandom_range(1, 8);
            repeat (count) begin
               if ($urandom_range(0, 3) == 0)
                  send_start(7'($urandom_range(0, 79)), 4'($urandom_range(0, 15)),
                             1'($urandom_range(0, 1)));
               else
                  send_data(8'($urandom));
            end
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("covered %0d requests: %0d headers, %0d complete sectors",
               total_requests, sb.headers_sent, sb.sectors_closed);
      $display("checked %0d disk bytes, %0d errors", sb.results_seen, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
